>>> src/pcmuh_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the microcode table of the PCM unpack and hold resampler.
// No dependencies; every other file imports this package.
package pcmuh_pkg;

  localparam int unsigned RATIO_FRAC_BITS = 16;
  localparam int unsigned ACC_W = 24;
  localparam int unsigned SAMPLE_W = 24;
  localparam int unsigned RATIO_W = 23;
  localparam int unsigned CFG_DATA_W = 23;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [ACC_W-1:0] ACC_INC = (RATIO_FRAC_BITS >= ACC_W - 1) ?
    ACC_W'((1 << (ACC_W - 1)) - 1) : ACC_W'(1 << RATIO_FRAC_BITS);

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RATIO = 2'd2;

  localparam logic [1:0] RST_WIDTH_MODE = 2'd1;
  localparam logic [1:0] RST_CHANNELS = 2'd2;
  localparam logic [RATIO_W-1:0] RST_RATIO = 23'd65536;

  typedef logic [1:0] step_t;

  localparam step_t STEP_TAKE = 2'd0;
  localparam step_t STEP_ADD = 2'd1;
  localparam step_t STEP_TEST = 2'd2;
  localparam step_t STEP_EMIT = 2'd3;

  typedef enum logic [1:0] {
    JC_ALWAYS,
    JC_FRAME,
    JC_ACC_POS,
    JC_EMIT
  } jcond_t;

  typedef struct packed {
    logic   accept;
    logic   acc_add;
    logic   emit;
    jcond_t jc;
    step_t  t_true;
    step_t  t_false;
  } uword_t;

  typedef struct packed {
    logic frame_done;
    logic acc_pos;
    logic slot_free;
    logic burst_end;
  } ustat_t;

  function automatic uword_t ucode(step_t s);
    uword_t w;
    w = '0;
    unique case (s)
      STEP_TAKE: begin
        w.accept = 1'b1;
        w.jc = JC_FRAME;
        w.t_true = STEP_ADD;
        w.t_false = STEP_TAKE;
      end
      STEP_ADD: begin
        w.acc_add = 1'b1;
        w.jc = JC_ALWAYS;
        w.t_true = STEP_TEST;
        w.t_false = STEP_TEST;
      end
      STEP_TEST: begin
        w.jc = JC_ACC_POS;
        w.t_true = STEP_EMIT;
        w.t_false = STEP_TAKE;
      end
      STEP_EMIT: begin
        w.emit = 1'b1;
        w.jc = JC_EMIT;
        w.t_true = STEP_EMIT;
        w.t_false = STEP_TAKE;
      end
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

>>> src/pcm_unpack_hold_resampler.sv
`timescale 1ns / 1ps
// Top level of the PCM byte unpacker with zero-order-hold rate converter.
// Depends on pcmuh_pkg, pcmuh_useq and pcmuh_dp.
//
// Raw little-endian PCM bytes enter one per beat on the in_ stream. Samples of 8, 16
// or 24 bits, mono or stereo, are assembled and left-justified to signed Q1.23; 8-bit
// data is offset binary. Each finished frame is held and the phase accumulator gains
// one unit; while the phase is positive the ratio is subtracted and the held frame is
// sent as one beat on the out_ stream, up to MAX_BURST beats per input byte. tlast
// marks the final beat caused by a byte. Bytes that finish no frame cause no beat.
// Steps: a byte that does not end a frame is taken and the sequencer stays in the take
// step. A frame-ending byte runs the microcode steps take, add, test and then emit once
// per result beat; test returns to take with no beat if the phase is not positive.
// The emit step runs at one beat per cycle into the single output register; when the
// receiver stalls, the sequencer waits in that step and no byte is taken.
// Reset (synchronous, rst_n low) restores the register defaults (16-bit stereo,
// ratio 1.0) and clears the partial frame, held frame and phase.
// Configuration writes take effect at once; format writes drop any partial frame.
module pcm_unpack_hold_resampler
  import pcmuh_pkg::*;
#(
  parameter int unsigned MAX_BURST = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,    // [7:0] byte_value
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [47:0]           out_tdata,   // [23:0] left_sample, [47:24] right_sample
  output logic                  out_tlast
);

  uword_t              ctl;
  ustat_t              stat;
  logic [SAMPLE_W-1:0] left;
  logic [SAMPLE_W-1:0] right;

  pcmuh_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctl   (ctl)
  );

  pcmuh_dp #(
    .MAX_BURST (MAX_BURST)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .stat       (stat),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_byte    (in_tdata),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_left   (left),
    .out_right  (right),
    .out_tlast  (out_tlast)
  );

  assign in_tready = ctl.accept;
  assign out_tdata = {right, left};

endmodule

>>> src/pcmuh_useq.sv
`timescale 1ns / 1ps
// Microcode sequencer: step counter, control store lookup and conditional jumps.
// Depends on pcmuh_pkg.
module pcmuh_useq
  import pcmuh_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  ustat_t stat,
  output uword_t ctl
);

  step_t step_r;
  step_t step_nxt;

  assign ctl = ucode(step_r);

  always_comb begin
    step_nxt = step_r;
    unique case (ctl.jc)
      JC_ALWAYS:  step_nxt = ctl.t_true;
      JC_FRAME:   step_nxt = stat.frame_done ? ctl.t_true : ctl.t_false;
      JC_ACC_POS: step_nxt = stat.acc_pos ? ctl.t_true : ctl.t_false;
      JC_EMIT: begin
        if (stat.slot_free) begin
          step_nxt = stat.burst_end ? ctl.t_false : ctl.t_true;
        end
      end
      default:    step_nxt = step_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_TAKE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

>>> src/pcmuh_dp.sv
`timescale 1ns / 1ps
// Datapath: configuration registers, byte assembly, held frame, phase accumulator,
// burst counter and output register. Depends on pcmuh_pkg.
module pcmuh_dp
  import pcmuh_pkg::*;
#(
  parameter int unsigned MAX_BURST = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  uword_t                ctl,
  output ustat_t                stat,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_tvalid,
  input  logic [7:0]            in_byte,
  input  logic                  out_tready,
  output logic                  out_tvalid,
  output logic [SAMPLE_W-1:0]   out_left,
  output logic [SAMPLE_W-1:0]   out_right,
  output logic                  out_tlast
);

  localparam int unsigned CNT_W = $clog2(MAX_BURST);

  logic [1:0]          width_mode_r;
  logic [1:0]          channels_r;
  logic [RATIO_W-1:0]  ratio_r;
  logic [23:0]         gather_r;
  logic [2:0]          byte_index_r;
  logic [SAMPLE_W-1:0] pending_left_r;
  logic [SAMPLE_W-1:0] held_left_r;
  logic [SAMPLE_W-1:0] held_right_r;
  logic [ACC_W-1:0]    acc_r;
  logic [CNT_W-1:0]    cnt_r;
  logic                out_valid_r;
  logic [SAMPLE_W-1:0] out_left_r;
  logic [SAMPLE_W-1:0] out_right_r;
  logic                out_last_r;

  logic [1:0]          bps;
  logic                stereo;
  logic [2:0]          frame_len;
  logic [2:0]          idx;
  logic [1:0]          pos;
  logic [23:0]         gather_nxt;
  logic [SAMPLE_W-1:0] sample;
  logic                sample_done;
  logic                accept;
  logic [ACC_W:0]      add_sum;
  logic [ACC_W:0]      sub_sum;
  logic [ACC_W-1:0]    acc_inc_val;
  logic [ACC_W-1:0]    acc_sub_val;
  logic                emit_fire;

  assign bps = width_mode_r[1] ? 2'd3 : (width_mode_r + 2'd1);
  assign stereo = channels_r[1];
  assign frame_len = stereo ? {bps, 1'b0} : {1'b0, bps};
  assign idx = (byte_index_r >= frame_len) ? 3'd0 : byte_index_r;
  assign pos = (idx >= {1'b0, bps}) ? 2'(idx - {1'b0, bps}) : idx[1:0];

  always_comb begin
    case (pos)
      2'd0:    gather_nxt = {16'd0, in_byte};
      2'd1:    gather_nxt = {gather_r[23:16], in_byte, gather_r[7:0]};
      default: gather_nxt = {in_byte, gather_r[15:0]};
    endcase
  end

  always_comb begin
    case (bps)
      2'd1:    sample = {~gather_nxt[7], gather_nxt[6:0], 16'd0};
      2'd2:    sample = {gather_nxt[15:0], 8'd0};
      default: sample = gather_nxt;
    endcase
  end

  assign accept = ctl.accept && in_tvalid;
  assign sample_done = ({1'b0, pos} + 3'd1) == {1'b0, bps};

  assign add_sum = {acc_r[ACC_W-1], acc_r} + {1'b0, ACC_INC};
  assign sub_sum = {acc_r[ACC_W-1], acc_r} - {{(ACC_W+1-RATIO_W){1'b0}}, ratio_r};
  assign acc_inc_val = (add_sum[ACC_W] != add_sum[ACC_W-1]) ?
    {add_sum[ACC_W], {(ACC_W-1){~add_sum[ACC_W]}}} : add_sum[ACC_W-1:0];
  assign acc_sub_val = (sub_sum[ACC_W] != sub_sum[ACC_W-1]) ?
    {sub_sum[ACC_W], {(ACC_W-1){~sub_sum[ACC_W]}}} : sub_sum[ACC_W-1:0];

  assign stat.frame_done = accept && sample_done && ((idx + 3'd1) == frame_len);
  assign stat.acc_pos = !acc_r[ACC_W-1] && (acc_r != '0);
  assign stat.slot_free = !out_valid_r || out_tready;
  assign stat.burst_end = acc_sub_val[ACC_W-1] || (acc_sub_val == '0) ||
                          (cnt_r == CNT_W'(MAX_BURST - 1));

  assign emit_fire = ctl.emit && stat.slot_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_mode_r <= RST_WIDTH_MODE;
      channels_r <= RST_CHANNELS;
      ratio_r <= RST_RATIO;
      gather_r <= '0;
      byte_index_r <= '0;
      pending_left_r <= '0;
      held_left_r <= '0;
      held_right_r <= '0;
      acc_r <= '0;
      cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_WIDTH_MODE: begin
            width_mode_r <= cfg_data[1:0];
            gather_r <= '0;
            byte_index_r <= '0;
          end
          REG_CHANNELS: begin
            channels_r <= cfg_data[1:0];
            gather_r <= '0;
            byte_index_r <= '0;
          end
          REG_RATIO: ratio_r <= cfg_data[RATIO_W-1:0];
          default: ;
        endcase
      end else if (accept) begin
        gather_r <= gather_nxt;
        if (!sample_done) begin
          byte_index_r <= idx + 3'd1;
        end else if (!stat.frame_done) begin
          pending_left_r <= sample;
          byte_index_r <= idx + 3'd1;
        end else begin
          byte_index_r <= '0;
          held_left_r <= stereo ? pending_left_r : sample;
          held_right_r <= sample;
        end
      end
      if (ctl.acc_add) begin
        acc_r <= acc_inc_val;
        cnt_r <= '0;
      end else if (emit_fire) begin
        acc_r <= acc_sub_val;
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (emit_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_left_r <= held_left_r;
      out_right_r <= held_right_r;
      out_last_r <= stat.burst_end;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_left = out_left_r;
  assign out_right = out_right_r;
  assign out_tlast = out_last_r;

  a_more_after_nonlast: assert property (@(posedge clk) disable iff (!rst_n)
    emit_fire && !stat.burst_end |=> stat.acc_pos)
    else $error("phase not positive after a non-final beat");

  a_count_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.acc_add |=> cnt_r == '0)
    else $error("burst counter not cleared at frame start");

  a_format_discard: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we && (cfg_index == REG_WIDTH_MODE || cfg_index == REG_CHANNELS)
    |=> byte_index_r == '0)
    else $error("partial frame kept across format change");

endmodule
